@@ rtl/speed_mapped_pwm_generator_assert.svh @@
// Assertion macros for the file that checks its own logic.
`ifndef SPEED_MAPPED_PWM_GENERATOR_ASSERT_SVH
`define SPEED_MAPPED_PWM_GENERATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SMPG_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SMPG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/smpg_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package smpg_pkg;

    localparam int TICKS_PER_SECOND_DEF = 1000000;

    localparam int SPEED_W = 15;
    localparam int DUTY_W  = 15;
    localparam int FREQ_W  = 14;
    localparam int CFG_W   = 15;
    localparam int CFG_IDX_W = 3;

    localparam logic [DUTY_W-1:0] DUTY_FULL = 15'd25600;
    // High time is (period * duty) / 25600, done as a shift by 10 and a division by 25.
    // The division by 25 is a multiply by a scaled reciprocal.
    localparam int DUTY_PRE_SHIFT = 10;
    localparam int DUTY_POST_DIV  = 25;

    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_FLOOR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_CEILING = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_FLOOR    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_CEILING  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_FLOOR    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_CEILING  = 3'd5;

    localparam logic [SPEED_W-1:0] RST_SPEED_FLOOR   = 15'd20;
    localparam logic [SPEED_W-1:0] RST_SPEED_CEILING = 15'd300;
    localparam logic [DUTY_W-1:0]  RST_DUTY_FLOOR    = 15'd5120;
    localparam logic [DUTY_W-1:0]  RST_DUTY_CEILING  = 15'd25600;
    localparam logic [FREQ_W-1:0]  RST_FREQ_FLOOR    = 14'd50;
    localparam logic [FREQ_W-1:0]  RST_FREQ_CEILING  = 14'd200;
    localparam logic [FREQ_W-1:0]  RST_FREQ_SETTING  = 14'd50;

    typedef struct packed {
        logic take_item;
        logic spd_chk;
        logic norm_latch;
        logic mul_duty;
        logic mul_freq;
        logic set_freq;
        logic tick_chk;
        logic period_latch;
        logic high_mul;
        logic high_latch;
        logic tick_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic spd_mid;
        logic tick_zero;
        logic duty_full;
        logic div_done;
    } t_status;

endpackage

`default_nettype wire

@@ rtl/smpg_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface smpg_in_if;
    logic               valid;
    logic               ready;
    logic               operation;
    logic signed [15:0] speed;

    modport source (output valid, output operation, output speed, input ready);
    modport sink   (input valid, input operation, input speed, output ready);
endinterface

`default_nettype wire

@@ rtl/smpg_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface smpg_out_if;
    logic                               valid;
    logic                               ready;
    logic                               pwm_level;
    logic [smpg_pkg::DUTY_W-1:0]        duty_now;
    logic [smpg_pkg::FREQ_W-1:0]        freq_now;

    modport source (output valid, output pwm_level, output duty_now, output freq_now,
                    input ready);
    modport sink   (input valid, input pwm_level, input duty_now, input freq_now,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/smpg_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle. o_done pulses when o_quo is valid.
module smpg_div #(
    parameter int NW = 31,
    parameter int DW = 15
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic               o_done,
    output logic [NW-1:0]      o_quo
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [DW:0]   w_shift;
    logic          w_ge;
    logic [DW:0]   w_diff;

    assign w_shift = {r_rem, r_quo[NW-1]};
    assign w_ge    = (w_shift >= {1'b0, r_den});
    assign w_diff  = w_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[NW-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DW-1:0] : w_shift[DW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

`default_nettype wire

@@ rtl/smpg_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module smpg_datapath #(
    parameter int TICKS_PER_SECOND = smpg_pkg::TICKS_PER_SECOND_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [smpg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [smpg_pkg::CFG_W-1:0]      i_cfg_data,
    input  wire logic signed [15:0]              i_speed,
    input  wire smpg_pkg::t_cmd                  i_cmd,
    output smpg_pkg::t_status                    o_status,
    output logic                                 o_pwm_level,
    output logic [smpg_pkg::DUTY_W-1:0]          o_duty_now,
    output logic [smpg_pkg::FREQ_W-1:0]          o_freq_now
);
    localparam int P_W    = $clog2(TICKS_PER_SECOND + 1);
    localparam int MA     = (P_W > 17) ? P_W : 17;
    localparam int PROD_W = MA + 15;
    localparam int NW     = smpg_pkg::SPEED_W + 16;
    localparam int DW     = 15;
    localparam int SW     = smpg_pkg::SPEED_W;
    localparam int DUW    = smpg_pkg::DUTY_W;
    localparam int FW     = smpg_pkg::FREQ_W;
    // Reciprocal of the post divisor, scaled so that the truncated product is exact
    // for every numerator of ZW bits.
    localparam int ZW     = PROD_W - smpg_pkg::DUTY_PRE_SHIFT;
    localparam int RK     = ZW + $clog2(smpg_pkg::DUTY_POST_DIV);
    localparam int MW     = RK + 1 - $clog2(smpg_pkg::DUTY_POST_DIV);
    localparam logic [MW-1:0] RECIP =
        MW'(((64'd1 << RK) + 64'(smpg_pkg::DUTY_POST_DIV - 1)) / 64'(smpg_pkg::DUTY_POST_DIV));

    // Configuration registers.
    logic [SW-1:0]  r_cfg_sf, r_cfg_sc;
    logic [DUW-1:0] r_cfg_df, r_cfg_dc;
    logic [FW-1:0]  r_cfg_ff, r_cfg_fc;

    // Working state.
    logic [SW-1:0]     r_s;
    logic [16:0]       r_norm;
    logic [PROD_W-1:0] r_prod;
    logic [DUW-1:0]    r_duty;
    logic [FW-1:0]     r_freq;
    logic [P_W-1:0]    r_period;
    logic [P_W-1:0]    r_high;
    logic [P_W-1:0]    r_tick;
    logic              r_level;
    logic              r_out_level;
    logic [DUW-1:0]    r_out_duty;
    logic [FW-1:0]     r_out_freq;

    logic [15:0]       w_neg;
    logic [SW-1:0]     w_abs;
    logic [SW:0]       w_sc;
    logic [DUW-1:0]    w_df, w_dc_lo, w_dc, w_dd;
    logic [FW-1:0]     w_ff, w_fc, w_fd;
    logic              w_s_zero, w_s_full, w_s_mid;
    logic [SW-1:0]     w_sdiff;
    logic [SW:0]       w_sden_full;
    logic [MA-1:0]     w_mul_a;
    logic [DUW-1:0]    w_mul_b;
    logic [PROD_W-1:0] w_prod;
    logic              w_div_start;
    logic [NW-1:0]     w_div_num;
    logic [DW-1:0]     w_div_den;
    logic              w_div_done;
    logic [NW-1:0]     w_div_quo;
    logic [P_W-1:0]    w_period_q;
    logic [P_W:0]      w_tick_inc;
    logic [FW-1:0]     w_freq_nz;
    logic [ZW-1:0]     w_hq_num;
    logic [ZW+MW-1:0]  w_hq_prod;
    logic [P_W-1:0]    w_high_q;

    // Magnitude of the signed speed; the most negative value saturates.
    assign w_neg = ~i_speed + 16'd1;
    assign w_abs = i_speed[15] ? (w_neg[15] ? {SW{1'b1}} : w_neg[SW-1:0])
                               : i_speed[SW-1:0];

    // Register corrections applied on use.
    assign w_sc    = (r_cfg_sc <= r_cfg_sf) ? ({1'b0, r_cfg_sf} + 16'd1) : {1'b0, r_cfg_sc};
    assign w_df    = (r_cfg_df > smpg_pkg::DUTY_FULL) ? smpg_pkg::DUTY_FULL : r_cfg_df;
    assign w_dc_lo = (r_cfg_dc < w_df) ? w_df : r_cfg_dc;
    assign w_dc    = (w_dc_lo > smpg_pkg::DUTY_FULL) ? smpg_pkg::DUTY_FULL : w_dc_lo;
    assign w_dd    = w_dc - w_df;
    assign w_ff    = (r_cfg_ff == '0) ? FW'(1) : r_cfg_ff;
    assign w_fc    = (r_cfg_fc < w_ff) ? w_ff : r_cfg_fc;
    assign w_fd    = w_fc - w_ff;

    assign w_s_zero    = (r_s <= r_cfg_sf);
    assign w_s_full    = ({1'b0, r_s} >= w_sc);
    assign w_s_mid     = !w_s_zero && !w_s_full;
    assign w_sdiff     = r_s - r_cfg_sf;
    assign w_sden_full = w_sc - {1'b0, r_cfg_sf};

    // One shared multiplier.
    assign w_mul_a = i_cmd.high_mul ? MA'(r_period) : MA'(r_norm);
    assign w_mul_b = i_cmd.mul_duty ? w_dd : (i_cmd.mul_freq ? DUW'(w_fd) : r_duty);
    assign w_prod  = w_mul_a * w_mul_b;

    // High time from the period-duty product: drop the low bits, then divide by 25.
    assign w_hq_num  = r_prod[PROD_W-1:smpg_pkg::DUTY_PRE_SHIFT];
    assign w_hq_prod = w_hq_num * RECIP;
    assign w_high_q  = w_hq_prod[RK +: P_W];

    assign w_freq_nz = (r_freq == '0) ? FW'(1) : r_freq;

    // One shared divider: speed fraction and period length.
    always_comb begin
        w_div_start = 1'b0;
        w_div_num   = '0;
        w_div_den   = '0;
        if (i_cmd.spd_chk) begin
            w_div_start = w_s_mid;
            w_div_num   = NW'({w_sdiff, 16'h0000});
            w_div_den   = w_sden_full[DW-1:0];
        end else if (i_cmd.tick_chk) begin
            w_div_start = (r_tick == '0);
            w_div_num   = NW'(TICKS_PER_SECOND);
            w_div_den   = DW'(w_freq_nz);
        end
    end

    smpg_div #(
        .NW (NW),
        .DW (DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    assign w_period_q = (w_div_quo[P_W-1:0] == '0) ? P_W'(1) : w_div_quo[P_W-1:0];
    assign w_tick_inc = {1'b0, r_tick} + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_sf <= smpg_pkg::RST_SPEED_FLOOR;
            r_cfg_sc <= smpg_pkg::RST_SPEED_CEILING;
            r_cfg_df <= smpg_pkg::RST_DUTY_FLOOR;
            r_cfg_dc <= smpg_pkg::RST_DUTY_CEILING;
            r_cfg_ff <= smpg_pkg::RST_FREQ_FLOOR;
            r_cfg_fc <= smpg_pkg::RST_FREQ_CEILING;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                smpg_pkg::CFG_SPEED_FLOOR:   r_cfg_sf <= i_cfg_data[SW-1:0];
                smpg_pkg::CFG_SPEED_CEILING: r_cfg_sc <= i_cfg_data[SW-1:0];
                smpg_pkg::CFG_DUTY_FLOOR:    r_cfg_df <= i_cfg_data[DUW-1:0];
                smpg_pkg::CFG_DUTY_CEILING:  r_cfg_dc <= i_cfg_data[DUW-1:0];
                smpg_pkg::CFG_FREQ_FLOOR:    r_cfg_ff <= i_cfg_data[FW-1:0];
                smpg_pkg::CFG_FREQ_CEILING:  r_cfg_fc <= i_cfg_data[FW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty   <= '0;
            r_freq   <= smpg_pkg::RST_FREQ_SETTING;
            r_period <= '0;
            r_high   <= '0;
            r_tick   <= '0;
            r_level  <= 1'b0;
        end else begin
            if (i_cmd.mul_freq) begin
                r_duty <= (r_norm == '0) ? '0 : w_df + DUW'(r_prod[PROD_W-1:16]);
            end
            if (i_cmd.set_freq) begin
                r_freq <= w_ff + FW'(r_prod[PROD_W-1:16]);
            end
            if (i_cmd.period_latch && w_div_done) begin
                r_period <= w_period_q;
            end
            if (i_cmd.high_mul && (r_duty >= smpg_pkg::DUTY_FULL)) begin
                r_high <= r_period;
            end
            if (i_cmd.high_latch) begin
                r_high <= w_high_q;
            end
            if (i_cmd.tick_step) begin
                r_level <= (r_tick < r_high);
                r_tick  <= (w_tick_inc >= {1'b0, r_period}) ? '0 : w_tick_inc[P_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_item) begin
            r_s <= w_abs;
        end
        if (i_cmd.spd_chk) begin
            r_norm <= w_s_zero ? 17'd0 : 17'h10000;
        end
        if (i_cmd.norm_latch && w_div_done) begin
            r_norm <= w_div_quo[16:0];
        end
        if (i_cmd.mul_duty || i_cmd.mul_freq || i_cmd.high_mul) begin
            r_prod <= w_prod;
        end
        if (i_cmd.out_load) begin
            r_out_level <= r_level;
            r_out_duty  <= r_duty;
            r_out_freq  <= r_freq;
        end
    end

    assign o_status.spd_mid   = w_s_mid;
    assign o_status.tick_zero = (r_tick == '0);
    assign o_status.duty_full = (r_duty >= smpg_pkg::DUTY_FULL);
    assign o_status.div_done  = w_div_done;

    assign o_pwm_level = r_out_level;
    assign o_duty_now  = r_out_duty;
    assign o_freq_now  = r_out_freq;
endmodule

`default_nettype wire

@@ rtl/smpg_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module smpg_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_op,
    output logic                   o_in_ready,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    input  wire smpg_pkg::t_status i_status,
    output smpg_pkg::t_cmd         o_cmd
);
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SPD_CHK  = 4'd1;
    localparam logic [3:0] S_SPD_DIV  = 4'd2;
    localparam logic [3:0] S_SPD_MULD = 4'd3;
    localparam logic [3:0] S_SPD_MULF = 4'd4;
    localparam logic [3:0] S_SPD_FREQ = 4'd5;
    localparam logic [3:0] S_TK_CHK   = 4'd6;
    localparam logic [3:0] S_TK_DIVP  = 4'd7;
    localparam logic [3:0] S_TK_MULH  = 4'd8;
    localparam logic [3:0] S_TK_HST   = 4'd9;
    localparam logic [3:0] S_TK_STEP  = 4'd10;
    localparam logic [3:0] S_FIN      = 4'd11;

    logic [3:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take_item = 1'b1;
                    n_state = i_in_op ? S_SPD_CHK : S_TK_CHK;
                end
            end
            S_SPD_CHK: begin
                o_cmd.spd_chk = 1'b1;
                n_state = i_status.spd_mid ? S_SPD_DIV : S_SPD_MULD;
            end
            S_SPD_DIV: begin
                o_cmd.norm_latch = 1'b1;
                if (i_status.div_done) begin
                    n_state = S_SPD_MULD;
                end
            end
            S_SPD_MULD: begin
                o_cmd.mul_duty = 1'b1;
                n_state = S_SPD_MULF;
            end
            S_SPD_MULF: begin
                o_cmd.mul_freq = 1'b1;
                n_state = S_SPD_FREQ;
            end
            S_SPD_FREQ: begin
                o_cmd.set_freq = 1'b1;
                n_state = S_FIN;
            end
            S_TK_CHK: begin
                o_cmd.tick_chk = 1'b1;
                n_state = i_status.tick_zero ? S_TK_DIVP : S_TK_STEP;
            end
            S_TK_DIVP: begin
                o_cmd.period_latch = 1'b1;
                if (i_status.div_done) begin
                    n_state = S_TK_MULH;
                end
            end
            S_TK_MULH: begin
                o_cmd.high_mul = 1'b1;
                n_state = i_status.duty_full ? S_TK_STEP : S_TK_HST;
            end
            S_TK_HST: begin
                o_cmd.high_latch = 1'b1;
                n_state = S_TK_STEP;
            end
            S_TK_STEP: begin
                o_cmd.tick_step = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                // Hold the finished result until the output register is free.
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
endmodule

`default_nettype wire

@@ rtl/speed_mapped_pwm_generator.sv @@
`timescale 1ns / 1ps
`default_nettype none

// PWM generator driven by one transaction per microsecond tick, with duty and
// frequency mapped linearly from the latest speed sample. Every input
// transaction (tick or speed sample) yields exactly one output transaction
// carrying the PWM level and the current duty and frequency settings. Items are
// handled one at a time through a small controller and a datapath that shares
// one multiplier and one restoring divider producing one quotient bit per cycle
// (NW = 31 quotient bits). The high time divides by a constant and uses a
// reciprocal multiply instead of the divider. A tick that starts a new period
// runs the divider once for the period length, and a speed sample inside the
// speed window runs it once for the speed fraction; other items do not use it.
// A finished result waits until the output register is free. The input is
// ready again in the cycle after the result is loaded, so the input is taken
// again as soon as the previous result sits in the output register, even while
// it waits there.
module speed_mapped_pwm_generator #(
    parameter int TICKS_PER_SECOND = smpg_pkg::TICKS_PER_SECOND_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    smpg_in_if.sink                             i_in,
    smpg_out_if.source                          o_out,
    input  wire logic                           i_cfg_we,
    input  wire logic [smpg_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [smpg_pkg::CFG_W-1:0]     i_cfg_data
);
    `include "speed_mapped_pwm_generator_assert.svh"

    smpg_pkg::t_cmd    w_cmd;
    smpg_pkg::t_status w_status;

    smpg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_op     (i_in.operation),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    smpg_datapath #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_speed     (i_in.speed),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_pwm_level (o_out.pwm_level),
        .o_duty_now  (o_out.duty_now),
        .o_freq_now  (o_out.freq_now)
    );

    // A new transaction is never taken while one is still being worked on.
    `SMPG_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n,
        i_in.valid && i_in.ready, !i_in.ready,
        "input accepted while previous item in work")

    // A result appears only when the controller loads the output register.
    `SMPG_ASSERT_IMPLIES(a_out_from_load, i_clk, i_rst_n,
        $rose(o_out.valid), $past(w_cmd.out_load),
        "output valid rose without a result load")

    // The duty setting never exceeds full scale.
    `SMPG_ASSERT_IMPLIES(a_duty_range, i_clk, i_rst_n,
        o_out.valid, o_out.duty_now <= smpg_pkg::DUTY_FULL,
        "duty setting above full scale")
endmodule

`default_nettype wire
